### rtl/nb2d_pkg.sv
// ----------------------------------------------------------------------------
// nb2d_pkg
// shared types and constants for the 2d gravity force engine
// ----------------------------------------------------------------------------
package nb2d_pkg;

   localparam int PosW   = 16;
   localparam int ForceW = 48;
   localparam int IdxW   = 4;
   localparam int OpW    = 2;

   localparam logic [ForceW-1:0] ForceMax = {1'b0, {(ForceW-1){1'b1}}};
   localparam logic [ForceW-1:0] ForceMin = {1'b1, {(ForceW-1){1'b0}}};

   typedef enum logic [OpW-1:0] {
      OP_LOAD  = 2'd0,
      OP_APPLY = 2'd1,
      OP_DRAIN = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // one queued command between front and back
   typedef struct packed {
      op_type            op;
      logic [PosW-1:0]   pos_x;
      logic [PosW-1:0]   pos_y;
      logic [PosW-1:0]   mass;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_DIVA,
      ST_DIVB,
      ST_ACC,
      ST_DRAIN
   } state_type;

endpackage

### rtl/nb2d_front.sv
// ----------------------------------------------------------------------------
// nb2d_front
// accepts items, drops unused op codes and holds a two-entry command queue
// ----------------------------------------------------------------------------
module nb2d_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  nb2d_pkg::op_type         req_op,
   input  logic [15:0]              req_pos_x,
   input  logic [15:0]              req_pos_y,
   input  logic [15:0]              req_mass,
   output logic                     cmd_valid,
   output nb2d_pkg::cmd_type        cmd,
   input  logic                     cmd_take
);

   nb2d_pkg::cmd_type q_ff [2];
   logic              wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall && (req_op != nb2d_pkg::OP_NONE);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = (cmd_take && cmd_valid) ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_take && cmd_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= '{op: req_op, pos_x: req_pos_x, pos_y: req_pos_y,
                          mass: req_mass};
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !(cmd_take && cmd_valid))
      else $error("take from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      push && !(cmd_take && cmd_valid) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("push lost");

endmodule

### rtl/nb2d_back.sv
// ----------------------------------------------------------------------------
// nb2d_back
// target store and force sequencer: one target at a time through a
// bit-serial square root and two bit-serial dividers, then saturating add
// ----------------------------------------------------------------------------
module nb2d_back #(
   parameter int MAX_TARGETS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  nb2d_pkg::cmd_type        cmd,
   output logic                     cmd_take,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [3:0]               rsp_body_index,
   output logic signed [47:0]       rsp_force_x,
   output logic signed [47:0]       rsp_force_y,
   output logic                     rsp_last
);

   localparam int TiW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam int CnW = $clog2(MAX_TARGETS + 1);

   logic [15:0] tx_mem [MAX_TARGETS];
   logic [15:0] ty_mem [MAX_TARGETS];
   logic [47:0] fx_mem [MAX_TARGETS];
   logic [47:0] fy_mem [MAX_TARGETS];

   nb2d_pkg::state_type st_ff, st_in;
   logic [CnW-1:0] cnt_ff;
   logic [TiW-1:0] ti_ff, ti_in;
   nb2d_pkg::cmd_type cur_ff;
   logic [15:0] tx_ff, ty_ff;
   logic [47:0] fx_ff, fy_ff;
   logic [6:0]  step_ff, step_in;

   // geometry
   logic signed [16:0] dx_ff, dy_ff;
   logic [32:0] r2_ff;
   logic [31:0] nx_ff, ny_ff;
   // sqrt of r2 << 30 (63 bits), result 32 bits
   logic [63:0] sv_ff;
   logic [33:0] srem_ff;
   logic [31:0] s_ff;
   // divider a = (n<<31)/r2, 63-bit numerator
   logic [62:0] anx_ff, any_ff;
   logic [33:0] arx_ff, ary_ff;
   // divider mag = (a<<32)/s, quotient up to 95 bits, clamp at 2^47
   logic [94:0] bnx_ff, bny_ff;
   logic [32:0] brx_ff, bry_ff;
   logic [47:0] mx_ff, my_ff;
   logic        ovx_ff, ovy_ff;

   // output register
   logic        ov_ff;
   logic [3:0]  oi_ff;
   logic [47:0] ox_ff, oy_ff;
   logic        ol_ff;

   assign rsp_valid      = ov_ff;
   assign rsp_body_index = oi_ff;
   assign rsp_force_x    = ox_ff;
   assign rsp_force_y    = oy_ff;
   assign rsp_last       = ol_ff;

   logic out_free;
   assign out_free = !ov_ff || !rsp_stall;

   function automatic logic [47:0] sat_add(input logic [47:0] acc, input logic [47:0] mag,
                                           input logic neg_d, input logic zero_d);
      logic signed [48:0] v;
      begin
         if (zero_d) begin
            sat_add = acc;
         end else begin
            if (neg_d) v = $signed({acc[47], acc}) + $signed({1'b0, mag});
            else       v = $signed({acc[47], acc}) - $signed({1'b0, mag});
            if (v[48] != v[47]) sat_add = v[48] ? nb2d_pkg::ForceMin : nb2d_pkg::ForceMax;
            else sat_add = v[47:0];
         end
      end
   endfunction

   // one restoring-division step on a shifting numerator
   logic [63:0] sq_op;
   logic [33:0] sq_t;
   logic [34:0] sq_r;
   logic [34:0] ax_t, ay_t;
   logic [33:0] bx_t, by_t;
   assign sq_op = {1'b0, r2_ff, 30'd0};
   always_comb begin
      sq_r = {srem_ff[32:0], sv_ff[63:62]};
      sq_t = {s_ff, 2'b01};
      ax_t = {arx_ff, anx_ff[62]};
      ay_t = {ary_ff, any_ff[62]};
      bx_t = {brx_ff, bnx_ff[94]};
      by_t = {bry_ff, bny_ff[94]};
   end

   logic cmd_go;
   always_comb begin
      st_in    = st_ff;
      step_in  = step_ff;
      ti_in    = ti_ff;
      cmd_go   = 1'b0;
      case (st_ff)
         nb2d_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_go = 1'b1;
               ti_in  = '0;
               if (cmd.op == nb2d_pkg::OP_APPLY && cnt_ff != '0) st_in = nb2d_pkg::ST_SQRT;
               else if (cmd.op == nb2d_pkg::OP_DRAIN && cnt_ff != '0)
                  st_in = nb2d_pkg::ST_DRAIN;
               step_in = '0;
            end
         end
         nb2d_pkg::ST_SQRT: begin
            // first step loads operands, then 32 root steps
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd32) begin
               st_in = (r2_ff == '0) ? nb2d_pkg::ST_ACC : nb2d_pkg::ST_DIVA;
               step_in = '0;
            end
         end
         nb2d_pkg::ST_DIVA: begin
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd62) begin
               st_in = nb2d_pkg::ST_DIVB;
               step_in = '0;
            end
         end
         nb2d_pkg::ST_DIVB: begin
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd94) st_in = nb2d_pkg::ST_ACC;
         end
         nb2d_pkg::ST_ACC: begin
            step_in = '0;
            if (CnW'(ti_ff) == CnW'(cnt_ff - 1'b1)) st_in = nb2d_pkg::ST_IDLE;
            else begin
               ti_in = ti_ff + TiW'(1);
               st_in = nb2d_pkg::ST_SQRT;
            end
         end
         nb2d_pkg::ST_DRAIN: begin
            if (out_free) begin
               if (CnW'(ti_ff) == CnW'(cnt_ff - 1'b1)) st_in = nb2d_pkg::ST_IDLE;
               else ti_in = ti_ff + TiW'(1);
            end
         end
         default: st_in = nb2d_pkg::ST_IDLE;
      endcase
   end
   assign cmd_take = cmd_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= nb2d_pkg::ST_IDLE;
         cnt_ff  <= '0;
         ti_ff   <= '0;
         step_ff <= '0;
         ov_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         ti_ff   <= ti_in;
         step_ff <= step_in;
         if (cmd_go && cmd.op == nb2d_pkg::OP_LOAD && cnt_ff < CnW'(MAX_TARGETS))
            cnt_ff <= cnt_ff + CnW'(1);
         if (st_ff == nb2d_pkg::ST_DRAIN && out_free) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
      end
   end

   // accumulator store, cleared per entry on load (reset gives zero via load)
   always_ff @(posedge clock) begin
      if (cmd_go && cmd.op == nb2d_pkg::OP_LOAD && cnt_ff < CnW'(MAX_TARGETS)) begin
         tx_mem[cnt_ff[TiW-1:0]] <= cmd.pos_x;
         ty_mem[cnt_ff[TiW-1:0]] <= cmd.pos_y;
         fx_mem[cnt_ff[TiW-1:0]] <= '0;
         fy_mem[cnt_ff[TiW-1:0]] <= '0;
      end else if (st_ff == nb2d_pkg::ST_ACC) begin
         fx_mem[ti_ff] <= sat_add(fx_ff, ovx_ff ? nb2d_pkg::ForceMax : mx_ff,
                                  dx_ff[16], dx_ff == '0 || r2_ff == '0);
         fy_mem[ti_ff] <= sat_add(fy_ff, ovy_ff ? nb2d_pkg::ForceMax : my_ff,
                                  dy_ff[16], dy_ff == '0 || r2_ff == '0);
      end
      tx_ff <= tx_mem[ti_in];
      ty_ff <= ty_mem[ti_in];
      fx_ff <= fx_mem[ti_in];
      fy_ff <= fy_mem[ti_in];
   end

   // datapath
   logic signed [16:0] dxn, dyn;
   logic [16:0] adx, ady;
   always_comb begin
      dxn = $signed({1'b0, tx_ff}) - $signed({1'b0, cur_ff.pos_x});
      dyn = $signed({1'b0, ty_ff}) - $signed({1'b0, cur_ff.pos_y});
      adx = dxn[16] ? 17'(-dxn) : 17'(dxn);
      ady = dyn[16] ? 17'(-dyn) : 17'(dyn);
   end

   always_ff @(posedge clock) begin
      if (cmd_go) cur_ff <= cmd;
      if (st_ff == nb2d_pkg::ST_DRAIN && out_free) begin
         oi_ff <= 4'(ti_ff);
         ox_ff <= fx_ff;
         oy_ff <= fy_ff;
         ol_ff <= (CnW'(ti_ff) == CnW'(cnt_ff - 1'b1));
      end
      case (st_ff)
         nb2d_pkg::ST_SQRT: begin
            if (step_ff == 7'd0) begin
               dx_ff   <= dxn;
               dy_ff   <= dyn;
               r2_ff   <= {1'b0, 32'(adx) * 32'(adx)} + {1'b0, 32'(ady) * 32'(ady)};
               nx_ff   <= 32'(adx) * 32'(cur_ff.mass);
               ny_ff   <= 32'(ady) * 32'(cur_ff.mass);
               sv_ff   <= '0;
               srem_ff <= '0;
               s_ff    <= '0;
            end else begin
               if (step_ff == 7'd1) begin
                  // operand is r2 << 30, placed as 64 bits
                  sv_ff <= sq_op << 2;
                  if (sq_op[63:62] != 2'b00) begin
                     srem_ff <= 34'(sq_op[63:62]) - 34'd1;
                     s_ff    <= 32'd1;
                  end else begin
                     srem_ff <= 34'(sq_op[63:62]);
                     s_ff    <= '0;
                  end
               end else begin
                  sv_ff <= sv_ff << 2;
                  if ({1'b0, sq_r} >= {2'b0, sq_t}) begin
                     srem_ff <= 34'(sq_r - 35'(sq_t));
                     s_ff    <= {s_ff[30:0], 1'b1};
                  end else begin
                     srem_ff <= 34'(sq_r);
                     s_ff    <= {s_ff[30:0], 1'b0};
                  end
               end
               anx_ff <= {nx_ff, 31'd0};
               any_ff <= {ny_ff, 31'd0};
               arx_ff <= '0;
               ary_ff <= '0;
            end
         end
         nb2d_pkg::ST_DIVA: begin
            anx_ff <= {anx_ff[61:0], (ax_t >= {2'b0, r2_ff})};
            arx_ff <= (ax_t >= {2'b0, r2_ff}) ? 34'(ax_t - {2'b0, r2_ff}) : 34'(ax_t);
            any_ff <= {any_ff[61:0], (ay_t >= {2'b0, r2_ff})};
            ary_ff <= (ay_t >= {2'b0, r2_ff}) ? 34'(ay_t - {2'b0, r2_ff}) : 34'(ay_t);
            if (step_ff == 7'd62) begin
               bnx_ff <= {anx_ff[61:0], (ax_t >= {2'b0, r2_ff}), 32'd0};
               bny_ff <= {any_ff[61:0], (ay_t >= {2'b0, r2_ff}), 32'd0};
               brx_ff <= '0;
               bry_ff <= '0;
               ovx_ff <= 1'b0;
               ovy_ff <= 1'b0;
            end
         end
         nb2d_pkg::ST_DIVB: begin
            bnx_ff <= {bnx_ff[93:0], (bx_t >= {2'b0, s_ff})};
            brx_ff <= (bx_t >= {2'b0, s_ff}) ? 33'(bx_t - {2'b0, s_ff}) : 33'(bx_t);
            bny_ff <= {bny_ff[93:0], (by_t >= {2'b0, s_ff})};
            bry_ff <= (by_t >= {2'b0, s_ff}) ? 33'(by_t - {2'b0, s_ff}) : 33'(by_t);
            // any quotient bit at weight 2^47 or above clamps
            if (step_ff < 7'd48) begin
               if (bx_t >= {2'b0, s_ff}) ovx_ff <= 1'b1;
               if (by_t >= {2'b0, s_ff}) ovy_ff <= 1'b1;
            end
            if (step_ff == 7'd94) begin
               mx_ff <= {bnx_ff[46:0], (bx_t >= {2'b0, s_ff})};
               my_ff <= {bny_ff[46:0], (by_t >= {2'b0, s_ff})};
            end
         end
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CnW'(MAX_TARGETS))
      else $error("target count overflow");
   assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> st_ff == nb2d_pkg::ST_IDLE)
      else $error("command taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped under stall");

endmodule

### rtl/nbody_2d_force_accumulator.sv
// ----------------------------------------------------------------------------
// nbody_2d_force_accumulator
// direct 2d gravity force engine with a target store and drain output
// ----------------------------------------------------------------------------
// req channel: op, pos_x, pos_y, mass; an item moves when req_valid is high
// and req_stall low. load stores a target and clears its force, apply
// streams one source over all stored targets, drain emits one rsp item per
// target in load order with rsp_last on the final one.
// a two-entry queue sits between intake and the force sequencer, so intake
// keeps taking items while the sequencer is busy, until the queue is full.
// apply takes the item, then for each stored target runs a 33-step
// bit-serial square root, a 63-step and a 95-step bit-serial divider
// (skipped when target and source coincide), then one accumulate step;
// the serial units set the rate.
// drain gives one rsp item per cycle while rsp_stall is low; a stall holds
// the current item and pauses the drain.
// reset (synchronous, active high) empties the queue and the target store.
// ----------------------------------------------------------------------------
module nbody_2d_force_accumulator #(
   parameter int MAX_TARGETS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [15:0]         req_pos_x,
   input  logic [15:0]         req_pos_y,
   input  logic [15:0]         req_mass,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_body_index,
   output logic signed [47:0]  rsp_force_x,
   output logic signed [47:0]  rsp_force_y,
   output logic                rsp_last
);

   logic              cmd_valid, cmd_take;
   nb2d_pkg::cmd_type cmd;

   nb2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (nb2d_pkg::op_type'(req_op)),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .req_mass  (req_mass),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   nb2d_back #(.MAX_TARGETS(MAX_TARGETS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_take       (cmd_take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_body_index (rsp_body_index),
      .rsp_force_x    (rsp_force_x),
      .rsp_force_y    (rsp_force_y),
      .rsp_last       (rsp_last)
   );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the 2d gravity force accumulator: a directed table
// of load, apply and drain items, then random body sets, checked field by
// field against a fixed-point force predictor kept inside the bench
// ----------------------------------------------------------------------------
module testbench;

   localparam int NTGT = 16;
   localparam logic signed [47:0] FMAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] FMIN = -48'sh7FFF_FFFF_FFFF - 48'sd1;

   typedef struct {
      logic [3:0]         idx;
      logic signed [47:0] fx;
      logic signed [47:0] fy;
      logic               last;
   } force_rsp_type;

   typedef struct {
      nb2d_pkg::op_type op;
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] m;
      bit          typed;
      logic signed [47:0] efx;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_op = '0;
   logic [15:0] req_pos_x = '0, req_pos_y = '0, req_mass = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_body_index;
   logic signed [47:0] rsp_force_x, rsp_force_y;
   logic rsp_last;

   logic [15:0] tgt_x [NTGT];
   logic [15:0] tgt_y [NTGT];
   logic signed [47:0] fx_acc [NTGT];
   logic signed [47:0] fy_acc [NTGT];
   int tgt_count = 0;
   force_rsp_type drain_q [$];
   int errors = 0;

   nbody_2d_force_accumulator u_dut (.*);

   always #4 clock = ~clock;

   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report(input string what);
      $display("error: %s", what);
      errors++;
   endtask

   function automatic logic [63:0] isqrt(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // q0.48 magnitude (lsb 2^-48) of |d|*m/r^3, truncated and clamped
   function automatic logic [63:0] axis_mag(input logic [63:0] ad, input logic [63:0] m,
                                            input logic [63:0] r2, input logic [63:0] s);
      logic [127:0] a, q;
      a = ((ad * m) << 31) / r2;
      q = (a << 32) / s;
      return (q > 128'h7FFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF : q[63:0];
   endfunction

   function automatic logic signed [47:0] axis_step(input logic signed [47:0] acc,
         input longint d, input logic [63:0] m, input logic [63:0] r2, input logic [63:0] s);
      longint mag, v;
      if (d == 0) return acc;
      mag = longint'(axis_mag(d < 0 ? -d : d, m, r2, s));
      v = (d > 0) ? longint'(acc) - mag : longint'(acc) + mag;
      if (v > longint'(FMAX)) return FMAX;
      if (v < longint'(FMIN)) return FMIN;
      return v[47:0];
   endfunction

   task automatic predict_forces(input nb2d_pkg::op_type op, input logic [15:0] px,
                                 input logic [15:0] py, input logic [15:0] m);
      longint dx, dy;
      logic [63:0] r2, s;
      force_rsp_type f;
      case (op)
         nb2d_pkg::OP_LOAD: begin
            if (tgt_count < NTGT) begin
               tgt_x[tgt_count] = px;
               tgt_y[tgt_count] = py;
               fx_acc[tgt_count] = 0;
               fy_acc[tgt_count] = 0;
               tgt_count++;
            end
         end
         nb2d_pkg::OP_APPLY: begin
            for (int i = 0; i < tgt_count; i++) begin
               dx = longint'(tgt_x[i]) - longint'(px);
               dy = longint'(tgt_y[i]) - longint'(py);
               r2 = dx * dx + dy * dy;
               if (r2 != 0) begin
                  s = isqrt(r2 << 30);
                  fx_acc[i] = axis_step(fx_acc[i], dx, m, r2, s);
                  fy_acc[i] = axis_step(fy_acc[i], dy, m, r2, s);
               end
            end
         end
         nb2d_pkg::OP_DRAIN: begin
            for (int i = 0; i < tgt_count; i++) begin
               f.idx = i[3:0];
               f.fx = fx_acc[i];
               f.fy = fy_acc[i];
               f.last = (i + 1 == tgt_count);
               drain_q.push_back(f);
            end
         end
         default: ;
      endcase
   endtask

   // valid stays high after an accept until a gap or an idle wait drops it
   task automatic send_item(input nb2d_pkg::op_type op, input logic [15:0] px,
                            input logic [15:0] py, input logic [15:0] m, input bit gap);
      int w;
      w = gap ? $urandom_range(0, 18) : 0;
      if (w != 0) begin
         req_valid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_pos_x <= px;
      req_pos_y <= py;
      req_mass <= m;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_forces(op, px, py, m);
   endtask

   // drains only complete after all earlier applies, so waiting for the queue is enough
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (drain_q.size() != 0) @(posedge clock);
   endtask

   // receiver: random stall per item, with stall-free stretches
   initial begin
      int w;
      bit calm;
      force_rsp_type e;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         calm = ($urandom_range(0, 3) == 0);
         w = calm ? 0 : $urandom_range(0, 18);
         if (w != 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (drain_q.size() == 0) begin
            report($sformatf("unexpected item idx %0d", rsp_body_index));
         end else begin
            e = drain_q.pop_front();
            if (rsp_body_index !== e.idx)
               report($sformatf("idx %0d exp %0d", rsp_body_index, e.idx));
            if (rsp_force_x !== e.fx)
               report($sformatf("idx %0d force_x %0d exp %0d", e.idx, rsp_force_x, e.fx));
            if (rsp_force_y !== e.fy)
               report($sformatf("idx %0d force_y %0d exp %0d", e.idx, rsp_force_y, e.fy));
            if (rsp_last !== e.last)
               report($sformatf("idx %0d last %0b exp %0b", e.idx, rsp_last, e.last));
         end
      end
   end

   stim_row_type dir [$];

   initial begin
      stim_row_type r;
      int ntg, nsrc;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // drain and apply with no targets, unused op, extremes, coincident pair, opposite corners
      dir.push_back('{nb2d_pkg::OP_DRAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0});
      dir.push_back('{nb2d_pkg::OP_NONE, 16'h1234, 16'h5678, 16'h9ABC, 0, 0});
      dir.push_back('{nb2d_pkg::OP_APPLY, 16'h0, 16'h0, 16'hFFFF, 0, 0});
      dir.push_back('{nb2d_pkg::OP_LOAD, 16'h0, 16'h0, 16'hFFFF, 0, 0});
      dir.push_back('{nb2d_pkg::OP_LOAD, 16'hFFFF, 16'hFFFF, 16'h0, 0, 0});
      dir.push_back('{nb2d_pkg::OP_LOAD, 16'h8000, 16'h0001, 16'h0, 0, 0});
      dir.push_back('{nb2d_pkg::OP_DRAIN, 16'h0, 16'h0, 16'h0, 1, 48'sd0});
      dir.push_back('{nb2d_pkg::OP_APPLY, 16'h0, 16'h0, 16'hFFFF, 0, 0});
      dir.push_back('{nb2d_pkg::OP_APPLY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0});
      dir.push_back('{nb2d_pkg::OP_APPLY, 16'h0, 16'h1, 16'hFFFF, 0, 0});
      dir.push_back('{nb2d_pkg::OP_APPLY, 16'h8001, 16'h0001, 16'h0, 0, 0});
      dir.push_back('{nb2d_pkg::OP_APPLY, 16'h8000, 16'h0000, 16'hFFFF, 0, 0});
      dir.push_back('{nb2d_pkg::OP_APPLY, 16'h8000, 16'h0002, 16'hFFFF, 0, 0});
      dir.push_back('{nb2d_pkg::OP_DRAIN, 16'h0, 16'h0, 16'h0, 0, 0});
      dir.push_back('{nb2d_pkg::OP_DRAIN, 16'h0, 16'h0, 16'h0, 0, 0});
      foreach (dir[k]) begin
         r = dir[k];
         send_item(r.op, r.px, r.py, r.m, 1);
         if (r.typed) begin
            foreach (drain_q[j])
               if (drain_q[j].fx !== r.efx || drain_q[j].fy !== r.efx)
                  report("fresh target force not zero");
         end
      end
      wait_idle();
      // fill past capacity on top of the stored targets; overflow loads ignored
      for (int i = 0; i < 18; i++)
         send_item(nb2d_pkg::OP_LOAD, 16'($urandom), 16'($urandom), 16'($urandom),
                   $urandom_range(0, 1));
      send_item(nb2d_pkg::OP_APPLY, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1);
      send_item(nb2d_pkg::OP_DRAIN, 0, 0, 0, 1);
      wait_idle();
      // random part: targets persist and the store is already full, so further loads are ignored
      for (int set = 0; set < 20; set++) begin
         ntg = $urandom_range(0, 2);
         for (int i = 0; i < ntg; i++)
            send_item(nb2d_pkg::OP_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), 1);
         nsrc = $urandom_range(1, 6);
         for (int i = 0; i < nsrc; i++) begin
            case ($urandom_range(0, 9))
               0: send_item(nb2d_pkg::OP_NONE, 16'($urandom), 16'($urandom),
                            16'($urandom), 1);
               1: send_item(nb2d_pkg::OP_APPLY, tgt_x[$urandom_range(0, NTGT - 1)],
                            tgt_y[$urandom_range(0, NTGT - 1)], 16'hFFFF, 1);
               2: send_item(nb2d_pkg::OP_APPLY, tgt_x[0] ^ 16'($urandom_range(0, 1)),
                            tgt_y[0], 16'($urandom), 1);
               default: send_item(nb2d_pkg::OP_APPLY, 16'($urandom), 16'($urandom),
                                  16'($urandom), $urandom_range(0, 3) != 0);
            endcase
         end
         send_item(nb2d_pkg::OP_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom), 1);
      end
      wait_idle();
      repeat (400) @(posedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### files.f
rtl/nb2d_pkg.sv
rtl/nb2d_front.sv
rtl/nb2d_back.sv
rtl/nbody_2d_force_accumulator.sv
tb/testbench.sv
